FILE: rtl/core/bipc_pkg.sv
`timescale 1ns / 1ps

package bipc_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_ROWS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COLS = 1'd1;

    // stream payloads
    localparam int LAND_W      = 1;
    localparam int COUNT_W     = 21;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // one entry of the line store: the two rows above a column
    typedef struct packed {
        logic older;
        logic prev;
    } line_cell_t;

    // write side of the line store
    typedef struct packed {
        logic       en;
        line_cell_t entry;
    } line_wr_t;

endpackage

FILE: rtl/core/binary_image_boundary_pixel_count_unit.sv
`timescale 1ns / 1ps

// Coast-cell counter. Cells of a binary map (1 land, 0 sea) arrive one per
// word in raster order; a land cell is counted when any of its four
// neighbours is sea or lies outside the frame. On the last cell of the frame
// one word carrying the total goes out and a new frame starts. The block
// takes one cell per clock: the accept stage reads the column's two-row
// entry and its right-hand neighbour from a dual-read line store, and the
// next stage judges the cell above, writes the column back and updates the
// count, so a new cell can enter every cycle. After the last cell is taken,
// the total is written to a four-word buffer in which results queue; the
// input stalls only when that buffer, together with a result still in
// flight, is full. The line store holds MAX_COLS entries of two bits and is
// not cleared after reset (every entry is written before the frame reads
// it), so the block is ready at once. frame_rows and frame_cols: 0 acts as
// 1, a value above MAX_ROWS or MAX_COLS acts as that maximum. A size change
// in the middle of a frame takes effect on the next cell; if the position
// falls outside the new frame, the cell goes to the start of the next row,
// or, past the last row, the unfinished frame is dropped.
module binary_image_boundary_pixel_count_unit #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [bipc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bipc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // cell stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bipc_pkg::IN_TDATA_W-1:0]     s_tdata,   // [0] land, [7:1] zero
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bipc_pkg::OUT_TDATA_W-1:0]    m_tdata    // [20:0] coast_count, [23:21] zero
);

    localparam int COL_W    = $clog2(MAX_COLS + 1);
    localparam int ROW_W    = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RST_COLS = (MAX_COLS < 1024) ? MAX_COLS : 1024;
    localparam int RST_ROWS = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W    = 2;
    localparam int CNT_W    = 3;

    // ------------------------------------------------------------------
    // Frame size registers, held already clamped
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] rows_reg;
    logic [COL_W-1:0] cols_reg;
    logic [ROW_W-1:0] rows_cfg;
    logic [COL_W-1:0] cols_cfg;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            rows_cfg = ROW_W'(1);
            cols_cfg = COL_W'(1);
        end
        else
        begin
            rows_cfg = (32'(cfg_data) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : ROW_W'(cfg_data);
            cols_cfg = (32'(cfg_data) > MAX_COLS) ? COL_W'(MAX_COLS) : COL_W'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROW_W'(RST_ROWS);
            cols_reg <= COL_W'(RST_COLS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bipc_pkg::CFG_FRAME_ROWS: rows_reg <= rows_cfg;
                bipc_pkg::CFG_FRAME_COLS: cols_reg <= cols_cfg;
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: place the cell in the frame and issue the store reads
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] row_pos_reg, row_pos_next;
    logic [COL_W-1:0] col_pos_reg, col_pos_next;

    logic             accept;
    logic             wrap_col;
    logic [COL_W-1:0] c_eff;
    logic [COL_W-1:0] c_plus1;
    logic [ROW_W-1:0] r_step;
    logic [ROW_W-1:0] r_eff;
    logic [ROW_W-1:0] r_plus1;
    logic             drop;
    logic             last_col;
    logic             last_row;
    logic             frame_end;

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        wrap_col  = (col_pos_reg >= cols_reg);
        c_eff     = wrap_col ? '0 : col_pos_reg;
        r_step    = wrap_col ? ROW_W'(row_pos_reg + ROW_W'(1)) : row_pos_reg;
        drop      = (r_step >= rows_reg);
        r_eff     = drop ? '0 : r_step;
        c_plus1   = COL_W'(c_eff + COL_W'(1));
        r_plus1   = ROW_W'(r_eff + ROW_W'(1));
        last_col  = (c_plus1 >= cols_reg);
        last_row  = (r_plus1 == rows_reg);
        frame_end = last_row && last_col;

        priority if (frame_end)
        begin
            col_pos_next = '0;
            row_pos_next = '0;
        end
        else if (last_col)
        begin
            col_pos_next = '0;
            row_pos_next = r_plus1;
        end
        else
        begin
            col_pos_next = c_plus1;
            row_pos_next = r_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else if (accept)
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Judge stage registers
    // ------------------------------------------------------------------
    logic              v1_reg;
    logic              land1_reg;
    logic [ADDR_W-1:0] addr1_reg;
    logic              judge1_reg;     // a row above exists
    logic              top1_reg;       // the row above is the first row
    logic              first1_reg;     // leftmost column
    logic              lastc1_reg;     // rightmost column
    logic              lastr1_reg;     // last row of the frame
    logic              end1_reg;       // last cell of the frame
    logic              clear1_reg;     // unfinished frame dropped

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            end1_reg   <= 1'b0;
            clear1_reg <= 1'b0;
        end
        else
        begin
            v1_reg     <= accept;
            end1_reg   <= accept && frame_end;
            clear1_reg <= accept && drop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            land1_reg  <= s_tdata[0];
            addr1_reg  <= c_eff[ADDR_W-1:0];
            judge1_reg <= (r_eff != '0);
            top1_reg   <= (r_eff == ROW_W'(1));
            first1_reg <= (c_eff == '0);
            lastc1_reg <= last_col;
            lastr1_reg <= last_row;
        end
    end

    // ------------------------------------------------------------------
    // Line store
    // ------------------------------------------------------------------
    bipc_pkg::line_wr_t   store_wr;
    bipc_pkg::line_cell_t centre_cell;
    bipc_pkg::line_cell_t right_cell;

    bipc_line_store #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .clk       (clk),
        .wr        (store_wr),
        .wr_addr   (addr1_reg),
        .rd_addr_a (c_eff[ADDR_W-1:0]),
        .rd_addr_b (c_plus1[ADDR_W-1:0]),
        .rd_cell_a (centre_cell),
        .rd_cell_b (right_cell)
    );

    // shift the column down: the row above becomes the older row
    always_comb
    begin
        store_wr.en          = v1_reg;
        store_wr.entry.older = centre_cell.prev;
        store_wr.entry.prev  = land1_reg;
    end

    // ------------------------------------------------------------------
    // Judge the cell above and update the count
    // ------------------------------------------------------------------
    logic               left_reg;      // cell above-left, as it stood
    logic               coast;
    logic [1:0]         inc;
    logic [bipc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [bipc_pkg::COUNT_W-1:0] count_base;
    logic [bipc_pkg::COUNT_W-1:0] count_sum;

    always_comb
    begin
        coast = centre_cell.prev &&
                (top1_reg || !centre_cell.older ||
                 first1_reg || !left_reg ||
                 lastc1_reg || !right_cell.prev ||
                 !land1_reg);
        inc   = {1'b0, judge1_reg && coast} + {1'b0, lastr1_reg && land1_reg};
        count_base = clear1_reg ? '0 : count_reg;
        count_sum  = bipc_pkg::COUNT_W'(count_base + bipc_pkg::COUNT_W'(inc));

        priority if (!v1_reg)
        begin
            count_next = count_reg;
        end
        else if (end1_reg)
        begin
            count_next = '0;
        end
        else
        begin
            count_next = count_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            left_reg <= centre_cell.prev;
        end
    end

    // ------------------------------------------------------------------
    // Result buffer
    // ------------------------------------------------------------------
    logic [bipc_pkg::COUNT_W-1:0] fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             push;
    logic             pop;
    logic [CNT_W-1:0] in_flight;

    assign push      = end1_reg;
    assign pop       = m_tvalid && m_tready;
    assign in_flight = CNT_W'(fill_reg + CNT_W'(push));

    // hold the input while a new result could find no room
    assign s_tready = (in_flight < CNT_W'(FIFO_DEPTH));

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   fill_next = CNT_W'(fill_reg + CNT_W'(1));
            2'b01:   fill_next = CNT_W'(fill_reg - CNT_W'(1));
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= PTR_W'(wr_ptr_reg + PTR_W'(1));
            end
            if (pop)
            begin
                rd_ptr_reg <= PTR_W'(rd_ptr_reg + PTR_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= count_sum;
        end
    end

    assign m_tvalid = (fill_reg != '0);
    assign m_tdata  = {{(bipc_pkg::OUT_TDATA_W - bipc_pkg::COUNT_W){1'b0}},
                       fifo_reg[rd_ptr_reg]};

endmodule

FILE: rtl/core/bipc_line_store.sv
`timescale 1ns / 1ps

// Two-row line store: one write port, two read ports, read data registered.
// A read of the entry being written in the same cycle returns the new value.
module bipc_line_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                  clk,
    input  bipc_pkg::line_wr_t    wr,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [ADDR_W-1:0]     rd_addr_a,
    input  logic [ADDR_W-1:0]     rd_addr_b,
    output bipc_pkg::line_cell_t  rd_cell_a,
    output bipc_pkg::line_cell_t  rd_cell_b
);

    bipc_pkg::line_cell_t mem [DEPTH];
    bipc_pkg::line_cell_t rd_a_reg;
    bipc_pkg::line_cell_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.entry;
        end
    end

    // forward the word being written past the array
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr_addr == rd_addr_a))
        begin
            rd_a_reg <= wr.entry;
        end
        else
        begin
            rd_a_reg <= mem[rd_addr_a];
        end
        if (wr.en && (wr_addr == rd_addr_b))
        begin
            rd_b_reg <= wr.entry;
        end
        else
        begin
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_cell_a = rd_a_reg;
    assign rd_cell_b = rd_b_reg;

endmodule
